/* hdl/gle_pkg.sv */
// ----------------------------------------------------------------------------
// gle_pkg: shared types and constants for the geodetic to local ENU block
// Operand widths of the serial units, WGS84 constants, CORDIC arctangents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gle_pkg;

  localparam int unsigned TRIG_ITER_DEF = 24;

  // serial multiplier: signed operands, full product, Q30-rounded product
  localparam int unsigned MW   = 34;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned RW   = PW - 30;
  localparam int unsigned MCW  = $clog2(MW);

  // divide / square root unit
  localparam int unsigned NW   = 62;
  localparam int unsigned DCW  = $clog2(NW);

  // ENU accumulators
  localparam int unsigned AW   = 40;

  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;
  localparam logic signed [MW-1:0] E2_Q32   = 34'sd28752144;
  localparam logic [30:0] A_SEMI_256        = 31'd1632803072;

  typedef enum logic [0:0] {
    DS_DIV,
    DS_SQRT
  } ds_op_e;

  typedef enum logic [2:0] {
    US_IDLE,
    US_RUN,
    US_FIX,
    US_RND,
    US_DONE
  } unit_state_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG_LAT,
    ST_COR_LAT,
    ST_ANG_LON,
    ST_COR_LON,
    ST_S2,
    ST_E2S2,
    ST_SQRT,
    ST_DIVN,
    ST_NE2,
    ST_T1,
    ST_X,
    ST_Y,
    ST_Z,
    ST_ORG,
    ST_DIFF,
    ST_PSC,
    ST_PSS,
    ST_PCC,
    ST_PCS,
    ST_E1,
    ST_E2T,
    ST_N1,
    ST_N2,
    ST_N3,
    ST_U1,
    ST_U2,
    ST_U3,
    ST_OUT
  } seq_state_e;

  // arctangent of 2^-i in binary angle (2^32 per turn), truncated
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      5'd24: v = 32'd40;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/gle_cordic.sv */
// ----------------------------------------------------------------------------
// gle_cordic: iterative rotation CORDIC
// One micro-rotation per cycle; angle folded into +-90 deg before the loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gle_cordic import gle_pkg::*; #(
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        ang_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned CW = $clog2(TRIG_ITERATIONS + 1);

  unit_state_e state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic flip_q;
  logic signed [31:0] sin_q, cos_q;

  logic signed [33:0] z_in, z_fold;
  logic flip_in;
  logic [4:0] idx;
  logic signed [33:0] xs, ys, at, x_n, y_n, z_n, nx, ny;

  always_comb begin
    z_in    = 34'(signed'(ang_i));
    z_fold  = z_in;
    flip_in = 1'b0;
    if (z_in > 34'sd1073741824) begin
      z_fold  = z_in - 34'sd2147483648;
      flip_in = 1'b1;
    end else if (z_in < -34'sd1073741824) begin
      z_fold  = z_in + 34'sd2147483648;
      flip_in = 1'b1;
    end
  end

  always_comb begin
    idx = 5'(cnt_q);
    xs  = x_q >>> idx;
    ys  = y_q >>> idx;
    at  = $signed({2'b00, atan_lut(idx)});
    if (!z_q[33]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
    nx = -x_q;
    ny = -y_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      US_IDLE: if (start_i) state_d = US_RUN;
      US_RUN:  if (cnt_q == CW'(TRIG_ITERATIONS - 1)) state_d = US_FIX;
      US_FIX:  state_d = US_DONE;
      US_DONE: state_d = US_IDLE;
      default: state_d = US_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == US_DONE);
    sin_o  = sin_q;
    cos_o  = cos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= US_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == US_IDLE) cnt_q <= '0;
      else if (state_q == US_RUN) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      US_IDLE: begin
        if (start_i) begin
          x_q    <= CORDIC_K;
          y_q    <= '0;
          z_q    <= z_fold;
          flip_q <= flip_in;
        end
      end
      US_RUN: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
      US_FIX: begin
        sin_q <= flip_q ? ny[31:0] : y_q[31:0];
        cos_q <= flip_q ? nx[31:0] : x_q[31:0];
      end
      default: ;
    endcase
  end

endmodule

/* hdl/gle_mul.sv */
// ----------------------------------------------------------------------------
// gle_mul: bit-serial signed multiplier
// Shift-add on magnitudes, one multiplier bit per cycle, then sign and Q30
// rounding (add half, arithmetic shift) in two registered steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gle_mul import gle_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [MW-1:0] a_i,
  input  logic signed [MW-1:0] b_i,
  output logic                 done_o,
  output logic signed [PW-1:0] prod_o,
  output logic signed [RW-1:0] rnd_o
);

  unit_state_e state_q, state_d;
  logic [MCW-1:0] cnt_q;
  logic [MW-1:0] amag_q;
  logic [PW-1:0] acc_q;
  logic neg_q;
  logic signed [PW-1:0] prod_q;
  logic signed [RW-1:0] rnd_q;

  logic [MW:0] sum;
  logic signed [PW-1:0] rsum;
  logic [MW-1:0] bmag;

  always_comb begin
    sum  = {1'b0, acc_q[PW-1:MW]} + (acc_q[0] ? {1'b0, amag_q} : '0);
    rsum = prod_q + (PW'(1) <<< 29);
    bmag = b_i[MW-1] ? unsigned'(-b_i) : unsigned'(b_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      US_IDLE: if (start_i) state_d = US_RUN;
      US_RUN:  if (cnt_q == MCW'(MW - 1)) state_d = US_FIX;
      US_FIX:  state_d = US_RND;
      US_RND:  state_d = US_DONE;
      US_DONE: state_d = US_IDLE;
      default: state_d = US_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == US_DONE);
    prod_o = prod_q;
    rnd_o  = rnd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= US_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == US_IDLE) cnt_q <= '0;
      else if (state_q == US_RUN) cnt_q <= cnt_q + MCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      US_IDLE: begin
        if (start_i) begin
          amag_q <= a_i[MW-1] ? unsigned'(-a_i) : unsigned'(a_i);
          acc_q  <= {{MW{1'b0}}, bmag};
          neg_q  <= a_i[MW-1] ^ b_i[MW-1];
        end
      end
      US_RUN: acc_q  <= {sum, acc_q[MW-1:1]};
      US_FIX: prod_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
      US_RND: rnd_q  <= rsum[PW-1:30];
      default: ;
    endcase
  end

endmodule

/* hdl/gle_ds.sv */
// ----------------------------------------------------------------------------
// gle_ds: serial restoring divider and square root
// Divide takes one dividend bit per cycle, square root two radicand bits;
// both share the remainder register and the trial subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gle_ds import gle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ds_op_e        op_i,
  input  logic [NW-1:0] num_i,
  input  logic [31:0]   den_i,
  output logic          done_o,
  output logic [31:0]   res_o
);

  unit_state_e state_q, state_d;
  ds_op_e op_q;
  logic [DCW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [31:0] den_q;
  logic [34:0] rem_q;
  logic [31:0] res_q;

  logic [34:0] t, trial, diff;
  logic ge, last;

  always_comb begin
    if (op_q == DS_SQRT) begin
      t     = {rem_q[32:0], num_q[NW-1:NW-2]};
      trial = {1'b0, res_q, 2'b01};
      last  = (cnt_q == DCW'(NW / 2 - 1));
    end else begin
      t     = {2'b00, rem_q[31:0], num_q[NW-1]};
      trial = {3'b000, den_q};
      last  = (cnt_q == DCW'(NW - 1));
    end
    ge   = (t >= trial);
    diff = t - trial;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      US_IDLE: if (start_i) state_d = US_RUN;
      US_RUN:  if (last) state_d = US_DONE;
      US_DONE: state_d = US_IDLE;
      default: state_d = US_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == US_DONE);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= US_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == US_IDLE) cnt_q <= '0;
      else if (state_q == US_RUN) cnt_q <= cnt_q + DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      US_IDLE: begin
        if (start_i) begin
          op_q  <= op_i;
          num_q <= num_i;
          den_q <= den_i;
          rem_q <= '0;
          res_q <= '0;
        end
      end
      US_RUN: begin
        rem_q <= ge ? diff : t;
        res_q <= {res_q[30:0], ge};
        num_q <= (op_q == DS_SQRT) ? {num_q[NW-3:0], 2'b00} : {num_q[NW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

endmodule

/* hdl/geodetic_to_local_enu.sv */
// ----------------------------------------------------------------------------
// geodetic_to_local_enu: WGS84 fix to east/north/up offsets from an origin
// Input words (s_axis) carry latitude, longitude (2^-22 deg) and altitude
// (1/256 m); tuser = 1 makes the fix the new origin. The first fix after
// reset always becomes the origin. Each input word gives one output word
// (m_axis): east, north, up in 1/256 m, saturated to 33 bits, and tuser set
// when that fix was taken as the origin (offsets then read zero).
// A sequencer walks each fix through shared serial units: a divider/square
// root (one dividend bit per cycle), an iterative CORDIC (one step per
// cycle) and a bit-serial multiplier that runs 19 products. Most of the
// time per word goes to the multiplier; one fix is in work at a time
// and tready is high only while the sequencer is idle.
// The result sits in an output register: a new fix is taken while it waits,
// and a stalled receiver only holds the sequencer at its last step.
// Reset clears the origin and drops both valids; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module geodetic_to_local_enu import gle_pkg::*; #(
  parameter int unsigned TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,   // latitude[29:0], longitude[60:30], altitude[86:61]
  input  logic [0:0]   s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // east[32:0], north[65:33], up[98:66]
  output logic [0:0]   m_axis_tuser    // origin_taken
);

  seq_state_e state_q, state_d;
  logic issued_q;

  logic act_q;
  logic signed [29:0] lat_q;
  logic signed [30:0] lon_q;
  logic signed [25:0] alt_q;

  logic [31:0] bang_q;
  logic signed [31:0] sl_q, cl_q, so_q, co_q;
  logic signed [MW-1:0] tmp_q, hn_q, hz_q, t1_q;
  logic [30:0] root_q;
  logic [31:0] n_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic org_vld_q, taken_q;
  logic signed [31:0] ox_q, oy_q, oz_q, osl_q, ocl_q, oso_q, oco_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [MW-1:0] psc_q, pss_q, pcc_q, pcs_q;
  logic signed [AW-1:0] e_q, n_acc_q, u_q;
  logic [103:0] out_q;
  logic out_user_q, m_valid_q;

  // unit handshakes
  logic mul_go, ds_go, cor_go, mul_start, ds_start, cor_start;
  logic mul_done, ds_done, cor_done, op_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_prod;
  logic signed [RW-1:0] mul_rnd;
  ds_op_e ds_op;
  logic [NW-1:0] ds_num;
  logic [31:0] ds_den, ds_res;
  logic signed [31:0] cor_sin, cor_cos;

  logic signed [30:0] deg_s;
  logic signed [37:0] tsh;
  logic [37:0] tmag;
  logic signed [AW-1:0] rnd_ext;
  logic out_load;

  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
    logic ovf;
    ovf = (v[RW-1:31] != {(RW - 31){v[RW-1]}});
    if (!ovf) return v[31:0];
    else if (v[RW-1]) return {1'b1, 31'b0};
    else return {1'b0, {31{1'b1}}};
  endfunction

  function automatic logic [32:0] sat33(input logic signed [AW-1:0] v);
    logic ovf;
    ovf = (v[AW-1:32] != {(AW - 32){v[AW-1]}});
    if (!ovf) return v[32:0];
    else if (v[AW-1]) return {1'b1, 32'b0};
    else return {1'b0, {32{1'b1}}};
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_user_q;

  assign op_done  = mul_done | ds_done | cor_done;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign rnd_ext  = AW'(mul_rnd);

  // degrees to binary angle: magnitude of deg*128, plus 22, over 45
  always_comb begin
    deg_s = (state_q == ST_ANG_LAT) ? 31'(lat_q) : lon_q;
    tsh   = {deg_s, 7'b0};
    tmag  = (deg_s[30] ? unsigned'(-tsh) : unsigned'(tsh)) + 38'd22;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_ANG_LAT;
      ST_ANG_LAT: if (op_done) state_d = ST_COR_LAT;
      ST_COR_LAT: if (op_done) state_d = ST_ANG_LON;
      ST_ANG_LON: if (op_done) state_d = ST_COR_LON;
      ST_COR_LON: if (op_done) state_d = ST_S2;
      ST_S2:      if (op_done) state_d = ST_E2S2;
      ST_E2S2:    if (op_done) state_d = ST_SQRT;
      ST_SQRT:    if (op_done) state_d = ST_DIVN;
      ST_DIVN:    if (op_done) state_d = ST_NE2;
      ST_NE2:     if (op_done) state_d = ST_T1;
      ST_T1:      if (op_done) state_d = ST_X;
      ST_X:       if (op_done) state_d = ST_Y;
      ST_Y:       if (op_done) state_d = ST_Z;
      ST_Z:       if (op_done) state_d = ST_ORG;
      ST_ORG:     state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_PSC;
      ST_PSC:     if (op_done) state_d = ST_PSS;
      ST_PSS:     if (op_done) state_d = ST_PCC;
      ST_PCC:     if (op_done) state_d = ST_PCS;
      ST_PCS:     if (op_done) state_d = ST_E1;
      ST_E1:      if (op_done) state_d = ST_E2T;
      ST_E2T:     if (op_done) state_d = ST_N1;
      ST_N1:      if (op_done) state_d = ST_N2;
      ST_N2:      if (op_done) state_d = ST_N3;
      ST_N3:      if (op_done) state_d = ST_U1;
      ST_U1:      if (op_done) state_d = ST_U2;
      ST_U2:      if (op_done) state_d = ST_U3;
      ST_U3:      if (op_done) state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // unit selection and operands
  always_comb begin
    mul_go = 1'b0;
    ds_go  = 1'b0;
    cor_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    ds_op  = DS_DIV;
    ds_num = '0;
    ds_den = '0;
    case (state_q)
      ST_ANG_LAT, ST_ANG_LON: begin
        ds_go  = 1'b1;
        ds_num = NW'(tmag);
        ds_den = 32'd45;
      end
      ST_COR_LAT, ST_COR_LON: cor_go = 1'b1;
      ST_S2: begin
        mul_go = 1'b1;
        mul_a  = MW'(sl_q);
        mul_b  = MW'(sl_q);
      end
      ST_E2S2: begin
        mul_go = 1'b1;
        mul_a  = E2_Q32;
        mul_b  = tmp_q;
      end
      ST_SQRT: begin
        ds_go  = 1'b1;
        ds_op  = DS_SQRT;
        ds_num = {1'b0, tmp_q[30:0], 30'b0};
      end
      ST_DIVN: begin
        ds_go  = 1'b1;
        ds_num = {1'b0, A_SEMI_256, root_q[30:1]};
        ds_den = {1'b0, root_q};
      end
      ST_NE2: begin
        mul_go = 1'b1;
        mul_a  = $signed({2'b00, n_q});
        mul_b  = E2_Q32;
      end
      ST_T1: begin
        mul_go = 1'b1;
        mul_a  = hn_q;
        mul_b  = MW'(cl_q);
      end
      ST_X: begin
        mul_go = 1'b1;
        mul_a  = t1_q;
        mul_b  = MW'(co_q);
      end
      ST_Y: begin
        mul_go = 1'b1;
        mul_a  = t1_q;
        mul_b  = MW'(so_q);
      end
      ST_Z: begin
        mul_go = 1'b1;
        mul_a  = hz_q;
        mul_b  = MW'(sl_q);
      end
      ST_PSC: begin
        mul_go = 1'b1;
        mul_a  = MW'(osl_q);
        mul_b  = MW'(oco_q);
      end
      ST_PSS: begin
        mul_go = 1'b1;
        mul_a  = MW'(osl_q);
        mul_b  = MW'(oso_q);
      end
      ST_PCC: begin
        mul_go = 1'b1;
        mul_a  = MW'(ocl_q);
        mul_b  = MW'(oco_q);
      end
      ST_PCS: begin
        mul_go = 1'b1;
        mul_a  = MW'(ocl_q);
        mul_b  = MW'(oso_q);
      end
      ST_E1: begin
        mul_go = 1'b1;
        mul_a  = MW'(oso_q);
        mul_b  = MW'(dx_q);
      end
      ST_E2T: begin
        mul_go = 1'b1;
        mul_a  = MW'(oco_q);
        mul_b  = MW'(dy_q);
      end
      ST_N1: begin
        mul_go = 1'b1;
        mul_a  = psc_q;
        mul_b  = MW'(dx_q);
      end
      ST_N2: begin
        mul_go = 1'b1;
        mul_a  = pss_q;
        mul_b  = MW'(dy_q);
      end
      ST_N3: begin
        mul_go = 1'b1;
        mul_a  = MW'(ocl_q);
        mul_b  = MW'(dz_q);
      end
      ST_U1: begin
        mul_go = 1'b1;
        mul_a  = pcc_q;
        mul_b  = MW'(dx_q);
      end
      ST_U2: begin
        mul_go = 1'b1;
        mul_a  = pcs_q;
        mul_b  = MW'(dy_q);
      end
      ST_U3: begin
        mul_go = 1'b1;
        mul_a  = MW'(osl_q);
        mul_b  = MW'(dz_q);
      end
      default: ;
    endcase
    mul_start = mul_go & ~issued_q;
    ds_start  = ds_go & ~issued_q;
    cor_start = cor_go & ~issued_q;
  end

  gle_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod),
    .rnd_o   (mul_rnd)
  );

  gle_ds u_ds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .op_i    (ds_op),
    .num_i   (ds_num),
    .den_i   (ds_den),
    .done_o  (ds_done),
    .res_o   (ds_res)
  );

  gle_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .ang_i   (bang_q),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      org_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= (issued_q | mul_start | ds_start | cor_start) & ~op_done;
      if (state_q == ST_ORG) org_vld_q <= 1'b1;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      act_q <= s_axis_tuser[0];
      lat_q <= s_axis_tdata[29:0];
      lon_q <= s_axis_tdata[60:30];
      alt_q <= s_axis_tdata[86:61];
    end
    if (op_done) begin
      case (state_q)
        ST_ANG_LAT, ST_ANG_LON: bang_q <= deg_s[30] ? -ds_res : ds_res;
        ST_COR_LAT: begin
          sl_q <= cor_sin;
          cl_q <= cor_cos;
        end
        ST_COR_LON: begin
          so_q <= cor_sin;
          co_q <= cor_cos;
        end
        ST_S2:   tmp_q <= mul_prod[30+MW-1:30];
        ST_E2S2: tmp_q <= (MW'(1) <<< 30) - $signed(mul_prod[32+MW-1:32]);
        ST_SQRT: root_q <= (ds_res[30:0] == '0) ? 31'd1 : ds_res[30:0];
        ST_DIVN: begin
          n_q  <= ds_res;
          hn_q <= MW'(alt_q) + $signed({2'b00, ds_res});
        end
        ST_NE2:  hz_q <= hn_q - $signed(mul_prod[32+MW-1:32]);
        ST_T1:   t1_q <= mul_rnd[MW-1:0];
        ST_X:    x_q <= sat32(mul_rnd);
        ST_Y:    y_q <= sat32(mul_rnd);
        ST_Z:    z_q <= sat32(mul_rnd);
        ST_PSC:  psc_q <= mul_rnd[MW-1:0];
        ST_PSS:  pss_q <= mul_rnd[MW-1:0];
        ST_PCC:  pcc_q <= mul_rnd[MW-1:0];
        ST_PCS:  pcs_q <= mul_rnd[MW-1:0];
        ST_E1:   e_q <= -rnd_ext;
        ST_E2T:  e_q <= e_q + rnd_ext;
        ST_N1:   n_acc_q <= -rnd_ext;
        ST_N2:   n_acc_q <= n_acc_q - rnd_ext;
        ST_N3:   n_acc_q <= n_acc_q + rnd_ext;
        ST_U1:   u_q <= rnd_ext;
        ST_U2:   u_q <= u_q + rnd_ext;
        ST_U3:   u_q <= u_q + rnd_ext;
        default: ;
      endcase
    end
    if (state_q == ST_ORG) begin
      taken_q <= act_q | ~org_vld_q;
      if (act_q || !org_vld_q) begin
        ox_q  <= x_q;
        oy_q  <= y_q;
        oz_q  <= z_q;
        osl_q <= sl_q;
        ocl_q <= cl_q;
        oso_q <= so_q;
        oco_q <= co_q;
      end
    end
    if (state_q == ST_DIFF) begin
      dx_q <= 33'(x_q) - 33'(ox_q);
      dy_q <= 33'(y_q) - 33'(oy_q);
      dz_q <= 33'(z_q) - 33'(oz_q);
    end
    if (out_load) begin
      out_q      <= {5'b0, sat33(u_q), sat33(n_acc_q), sat33(e_q)};
      out_user_q <= taken_q;
    end
  end

`ifndef SYNTH
  a_idle_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !issued_q)
    else $error("unit request outstanding while idle");

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_done, ds_done, cor_done}))
    else $error("more than one unit finished at once");

  a_origin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    org_vld_q |=> org_vld_q)
    else $error("origin lost without reset");

  a_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("origin word with nonzero offsets");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output valid raised outside final step");
`endif

endmodule
